// ===== rtl/bba_pkg.sv =====
// ----------------------------------------------------------------------------
// bba_pkg: shared definitions for the buddy bitmap allocator
// Sizes, bitmap word layout, status codes and the result record.
// ----------------------------------------------------------------------------
package bba_pkg;

  localparam int REGION_BLOCKS = 1024;
  localparam int ORDER_COUNT   = 11;
  localparam int TOP_ORDER     = ORDER_COUNT - 1;
  localparam int BLK_W         = $clog2(REGION_BLOCKS);
  localparam int POS_W         = BLK_W + 1;
  localparam int ORD_W         = 4;
  localparam int CNT_W         = $clog2(REGION_BLOCKS + 1);
  localparam int WORD_W        = 32;
  localparam int WORD_LG       = $clog2(WORD_W);

  // Number of bitmap words that hold one order.
  function automatic int words_f(input int o);
    int s;
    s = REGION_BLOCKS >> o;
    return (s > WORD_W) ? s / WORD_W : 1;
  endfunction

  // First bitmap word of an order.
  function automatic int word_base_f(input int o);
    int acc;
    acc = 0;
    for (int k = 0; k < o; k++) begin
      acc = acc + words_f(k);
    end
    return acc;
  endfunction

  localparam int MEM_WORDS = word_base_f(ORDER_COUNT);
  localparam int ADDR_W    = $clog2(MEM_WORDS);
  localparam int TOP_WORD  = word_base_f(TOP_ORDER);

  typedef logic [1:0] status_t;
  localparam status_t ST_OK       = 2'd0;
  localparam status_t ST_NOSPACE  = 2'd1;
  localparam status_t ST_MISALIGN = 2'd2;
  localparam status_t ST_TOOBIG   = 2'd3;

  typedef struct packed {
    status_t            status;
    logic [BLK_W-1:0]   gblk;
    logic [ORD_W-1:0]   gord;
    logic [CNT_W-1:0]   total;
  } result_t;

  // Index of the lowest set bit of a word.
  function automatic logic [WORD_LG-1:0] lsb_f(input logic [WORD_W-1:0] w);
    logic [WORD_LG-1:0] r;
    r = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (w[i]) begin
        r = WORD_LG'(i);
      end
    end
    return r;
  endfunction

endpackage

// ===== rtl/buddy_bitmap_allocator_core.sv =====
// ----------------------------------------------------------------------------
// buddy_bitmap_allocator_core: binary buddy allocator over a bitmap
// Allocates and frees power-of-two regions, one transaction at a time.
// ----------------------------------------------------------------------------
// The block takes one request transaction at a time and answers each with
// exactly one result transaction. All bitmap traffic goes through a single
// port on a 32-bit word store, so the latency depends on that port. A
// request with an error goes straight to the result. An allocate reads and
// clears the taken region, scans for the next free region of the taken
// order, then sets one buddy region for each order split. A free reads each
// buddy in turn and merges while the buddy is free, up to the top order,
// then sets the bit of the merged region, with the same scan each time a
// merged buddy was the first free region of its order. A scan reads one
// bitmap word at a time until it finds a free region or the order ends. No
// clearing pass is needed after reset, since each bitmap word carries a
// valid bit. The result register lets a finished result wait for out_ready,
// but a new request is only taken when idle.
module buddy_bitmap_allocator_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        action,
  input  logic [bba_pkg::ORD_W-1:0]   request_order,
  input  logic [bba_pkg::BLK_W-1:0]   block_index,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [1:0]                  status,
  output logic [bba_pkg::BLK_W-1:0]   granted_block,
  output logic [bba_pkg::ORD_W-1:0]   granted_order,
  output logic [bba_pkg::CNT_W-1:0]   free_block_total
);
  import bba_pkg::*;

  logic              seq_idle, seq_done, out_free;
  result_t           seq_res, res;
  logic              mem_rd, mem_wr;
  logic [ADDR_W-1:0] mem_addr;
  logic [WORD_W-1:0] mem_wdata, mem_rdata;

  // The output slot is free when empty or being emptied this cycle.
  assign out_free = !out_valid || out_ready;
  assign in_ready = seq_idle;

  bba_seq u_seq (
    .clk        (clk),
    .rst        (rst),
    .start      (in_valid && in_ready),
    .req_action (action),
    .req_order  (request_order),
    .req_block  (block_index),
    .out_free   (out_free),
    .idle       (seq_idle),
    .done       (seq_done),
    .result     (seq_res),
    .mem_rd     (mem_rd),
    .mem_wr     (mem_wr),
    .mem_addr   (mem_addr),
    .mem_wdata  (mem_wdata),
    .mem_rdata  (mem_rdata)
  );

  bba_bitmap u_bitmap (
    .clk   (clk),
    .rst   (rst),
    .rd_en (mem_rd),
    .wr_en (mem_wr),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (seq_done) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (seq_done) begin
      res <= seq_res;
    end
  end

  assign status           = res.status;
  assign granted_block    = res.gblk;
  assign granted_order    = res.gord;
  assign free_block_total = res.total;

endmodule

// ===== rtl/bba_bitmap.sv =====
// ----------------------------------------------------------------------------
// bba_bitmap: free bitmap word store
// One read or write port; per-word valid bits give the reset image.
// ----------------------------------------------------------------------------
module bba_bitmap (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        rd_en,
  input  logic                        wr_en,
  input  logic [bba_pkg::ADDR_W-1:0]  addr,
  input  logic [bba_pkg::WORD_W-1:0]  wdata,
  output logic [bba_pkg::WORD_W-1:0]  rdata
);
  import bba_pkg::*;

  logic [WORD_W-1:0]    mem [MEM_WORDS];
  logic [MEM_WORDS-1:0] word_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      word_valid <= '0;
    end else if (wr_en) begin
      word_valid[addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr] <= wdata;
    end
  end

  // A word never written reads as its reset image: only the top order is free.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (word_valid[addr]) begin
        rdata <= mem[addr];
      end else if (addr == ADDR_W'(TOP_WORD)) begin
        rdata <= WORD_W'(1);
      end else begin
        rdata <= '0;
      end
    end
  end

endmodule

// ===== rtl/bba_seq.sv =====
// ----------------------------------------------------------------------------
// bba_seq: allocator sequencer
// Steps allocate and free requests through the bitmap port one word at a time.
// ----------------------------------------------------------------------------
module bba_seq (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic                        req_action,
  input  logic [bba_pkg::ORD_W-1:0]   req_order,
  input  logic [bba_pkg::BLK_W-1:0]   req_block,
  input  logic                        out_free,
  output logic                        idle,
  output logic                        done,
  output bba_pkg::result_t            result,
  output logic                        mem_rd,
  output logic                        mem_wr,
  output logic [bba_pkg::ADDR_W-1:0]  mem_addr,
  output logic [bba_pkg::WORD_W-1:0]  mem_wdata,
  input  logic [bba_pkg::WORD_W-1:0]  mem_rdata
);
  import bba_pkg::*;

  typedef enum logic [12:0] {
    S_IDLE  = 13'b0000000000001,
    S_DEC   = 13'b0000000000010,
    S_ARD   = 13'b0000000000100,
    S_AWR   = 13'b0000000001000,
    S_SRD   = 13'b0000000010000,
    S_SCHK  = 13'b0000000100000,
    S_SPLIT = 13'b0000001000000,
    S_SPWR  = 13'b0000010000000,
    S_FRD   = 13'b0000100000000,
    S_FCHK  = 13'b0001000000000,
    S_FSRD  = 13'b0010000000000,
    S_FSWR  = 13'b0100000000000,
    S_DONE  = 13'b1000000000000
  } state_t;

  state_t state, ret_state;

  logic                  act;
  logic [ORD_W-1:0]      ord;
  logic [BLK_W-1:0]      blk;
  logic [ORD_W-1:0]      cur_ord;
  logic [BLK_W-1:0]      cur_nr;
  logic [ORD_W-1:0]      split_i;
  logic [ORD_W-1:0]      gord;
  logic [BLK_W-1:0]      gblk;
  logic [ORD_W-1:0]      scan_ord;
  logic [POS_W-1:0]      scan_pos;
  status_t               status;
  logic [CNT_W-1:0]      count;
  logic [ORDER_COUNT-1:0] ff_valid;
  logic [BLK_W-1:0]      ff_idx [ORDER_COUNT];

  logic [ADDR_W-1:0]     wbase [ORDER_COUNT];
  logic [ORD_W-1:0]      a_ord;
  logic [BLK_W-1:0]      a_nr;
  logic                  a_bit;
  logic [WORD_W-1:0]     a_mask;
  logic                  up_hit, dn_hit;
  logic [ORD_W-1:0]      up_f, dn_f, f_sel, g_sel;
  logic [BLK_W-1:0]      split_nr, bud_nr;
  logic [POS_W-1:0]      scan_size;
  logic [WORD_W-1:0]     scan_word;
  logic [CNT_W-1:0]      g_size, r_size;
  logic [CNT_W:0]        sum;

  always_comb begin
    for (int k = 0; k < ORDER_COUNT; k++) begin
      wbase[k] = ADDR_W'(word_base_f(k));
    end
  end

  // Order search: smallest free order at or above the request, else the
  // largest free order below it.
  always_comb begin
    up_hit = 1'b0;
    up_f   = '0;
    dn_hit = 1'b0;
    dn_f   = '0;
    for (int k = TOP_ORDER; k >= 0; k--) begin
      if (ff_valid[k] && (ORD_W'(k) >= ord)) begin
        up_hit = 1'b1;
        up_f   = ORD_W'(k);
      end
    end
    for (int k = 0; k < ORDER_COUNT; k++) begin
      if (ff_valid[k] && (ORD_W'(k) < ord)) begin
        dn_hit = 1'b1;
        dn_f   = ORD_W'(k);
      end
    end
    f_sel = up_hit ? up_f : dn_f;
    g_sel = (f_sel < ord) ? f_sel : ord;
  end

  assign split_nr  = BLK_W'(gblk >> split_i) ^ BLK_W'(1);
  assign bud_nr    = cur_nr ^ BLK_W'(1);
  assign scan_size = POS_W'(REGION_BLOCKS) >> scan_ord;
  assign scan_word = mem_rdata & ({WORD_W{1'b1}} << scan_pos[WORD_LG-1:0]);
  assign g_size    = CNT_W'(1) << gord;
  assign r_size    = CNT_W'(1) << ord;
  // One bit wider than the count, since a full region plus a top-order free
  // does not fit in the count width.
  assign sum       = {1'b0, count} + {1'b0, r_size};

  // Bitmap port address and read-modify-write data.
  always_comb begin
    a_ord = '0;
    a_nr  = '0;
    unique case (state)
      S_ARD, S_AWR, S_FSRD, S_FSWR: begin
        a_ord = cur_ord;
        a_nr  = cur_nr;
      end
      S_SPLIT, S_SPWR: begin
        a_ord = split_i;
        a_nr  = split_nr;
      end
      S_SRD, S_SCHK: begin
        a_ord = scan_ord;
        a_nr  = scan_pos[BLK_W-1:0];
      end
      S_FRD, S_FCHK: begin
        a_ord = cur_ord;
        a_nr  = bud_nr;
      end
      default: begin
        a_ord = '0;
        a_nr  = '0;
      end
    endcase
    mem_addr = wbase[a_ord] + ADDR_W'(a_nr[BLK_W-1:WORD_LG]);
    a_mask   = WORD_W'(1) << a_nr[WORD_LG-1:0];
    a_bit    = mem_rdata[a_nr[WORD_LG-1:0]];
    mem_rd   = (state == S_ARD) || (state == S_FSRD)
            || ((state == S_SRD) && (scan_pos < scan_size))
            || ((state == S_SPLIT) && (split_i != cur_ord))
            || ((state == S_FRD) && (cur_ord != ORD_W'(TOP_ORDER)));
    mem_wr   = (state == S_AWR) || (state == S_SPWR) || (state == S_FSWR)
            || ((state == S_FCHK) && a_bit);
    mem_wdata = ((state == S_AWR) || (state == S_FCHK)) ? (mem_rdata & ~a_mask)
                                                         : (mem_rdata | a_mask);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      ret_state <= S_IDLE;
      count    <= CNT_W'(REGION_BLOCKS);
      ff_valid <= ORDER_COUNT'(1) << TOP_ORDER;
      for (int k = 0; k < ORDER_COUNT; k++) begin
        ff_idx[k] <= '0;
      end
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start) begin
            act   <= req_action;
            ord   <= req_order;
            blk   <= req_block;
            state <= S_DEC;
          end
        end
        S_DEC: begin
          status <= ST_OK;
          gblk   <= '0;
          gord   <= '0;
          if (ord > ORD_W'(TOP_ORDER)) begin
            status <= ST_TOOBIG;
            state  <= S_DONE;
          end else if (!act) begin
            if (!up_hit && !dn_hit) begin
              status <= ST_NOSPACE;
              state  <= S_DONE;
            end else begin
              cur_ord <= f_sel;
              cur_nr  <= ff_idx[f_sel];
              split_i <= g_sel;
              gord    <= g_sel;
              gblk    <= BLK_W'(ff_idx[f_sel] << f_sel);
              state   <= S_ARD;
            end
          end else if ((blk & ((BLK_W'(1) << ord) - BLK_W'(1))) != '0) begin
            status <= ST_MISALIGN;
            state  <= S_DONE;
          end else begin
            cur_ord <= ord;
            cur_nr  <= blk >> ord;
            state   <= S_FRD;
          end
        end
        S_ARD: state <= S_AWR;
        S_AWR: begin
          // The taken region was the first free one of its order.
          scan_ord  <= cur_ord;
          scan_pos  <= POS_W'(cur_nr) + POS_W'(1);
          ret_state <= S_SPLIT;
          state     <= S_SRD;
        end
        S_SRD: begin
          if (scan_pos < scan_size) begin
            state <= S_SCHK;
          end else begin
            ff_valid[scan_ord] <= 1'b0;
            state <= ret_state;
          end
        end
        S_SCHK: begin
          if (scan_word != '0) begin
            ff_valid[scan_ord] <= 1'b1;
            ff_idx[scan_ord]   <= {scan_pos[BLK_W-1:WORD_LG], lsb_f(scan_word)};
            state <= ret_state;
          end else begin
            scan_pos <= {scan_pos[POS_W-1:WORD_LG] + (POS_W-WORD_LG)'(1),
                         WORD_LG'(0)};
            state    <= S_SRD;
          end
        end
        S_SPLIT: begin
          if (split_i == cur_ord) begin
            count <= (count >= g_size) ? count - g_size : '0;
            state <= S_DONE;
          end else begin
            state <= S_SPWR;
          end
        end
        S_SPWR: begin
          if (!ff_valid[split_i] || (split_nr < ff_idx[split_i])) begin
            ff_valid[split_i] <= 1'b1;
            ff_idx[split_i]   <= split_nr;
          end
          split_i <= split_i + ORD_W'(1);
          state   <= S_SPLIT;
        end
        S_FRD: begin
          state <= (cur_ord == ORD_W'(TOP_ORDER)) ? S_FSRD : S_FCHK;
        end
        S_FCHK: begin
          if (!a_bit) begin
            state <= S_FSRD;
          end else begin
            cur_nr  <= cur_nr >> 1;
            cur_ord <= cur_ord + ORD_W'(1);
            if (ff_valid[cur_ord] && (ff_idx[cur_ord] == bud_nr)) begin
              scan_ord  <= cur_ord;
              scan_pos  <= POS_W'(bud_nr) + POS_W'(1);
              ret_state <= S_FRD;
              state     <= S_SRD;
            end else begin
              state <= S_FRD;
            end
          end
        end
        S_FSRD: state <= S_FSWR;
        S_FSWR: begin
          if (!ff_valid[cur_ord] || (cur_nr < ff_idx[cur_ord])) begin
            ff_valid[cur_ord] <= 1'b1;
            ff_idx[cur_ord]   <= cur_nr;
          end
          count <= (sum > (CNT_W+1)'(REGION_BLOCKS)) ? CNT_W'(REGION_BLOCKS)
                                                      : sum[CNT_W-1:0];
          state <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign idle          = (state == S_IDLE);
  assign done          = (state == S_DONE) && out_free;
  assign result.status = status;
  assign result.gblk   = gblk;
  assign result.gord   = gord;
  assign result.total  = count;

endmodule

// ===== rtl/bba_checker.sv =====
// ----------------------------------------------------------------------------
// bba_checker: port-level checks for the allocator
// Watches the handshakes and result fields over time.
// ----------------------------------------------------------------------------
module bba_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [1:0]                  status,
  input logic [bba_pkg::BLK_W-1:0]   granted_block,
  input logic [bba_pkg::ORD_W-1:0]   granted_order,
  input logic [bba_pkg::CNT_W-1:0]   free_block_total
);
  import bba_pkg::*;

  // A stalled result keeps its status, granted block and free total.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status)
      && $stable(granted_block) && $stable(free_block_total))
    else $error("result changed while stalled");

  // Only one request is in flight at a time.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while busy");

  a_total: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> free_block_total <= CNT_W'(REGION_BLOCKS))
    else $error("free total above region size");

  // Failed results carry no grant: block and order both read as zero.
  a_err: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |-> granted_block == '0 && granted_order == '0)
    else $error("grant fields set on an error");

endmodule

bind buddy_bitmap_allocator_core bba_checker u_bba_checker (
  .clk              (clk),
  .rst              (rst),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .status           (status),
  .granted_block    (granted_block),
  .granted_order    (granted_order),
  .free_block_total (free_block_total)
);
